// ----- hdl/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the sequential list engine: capacity, widths,
// request codes and sequencer states.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int CAPACITY = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int FILL_W   = $clog2(CAPACITY + 1);
   localparam int POS_W    = 5;
   localparam int CMP_W    = (FILL_W > POS_W) ? FILL_W : POS_W;
   localparam int WORD_W   = 32;
   localparam int MPOS_W   = 4;
   localparam int CNT_W    = 5;

   localparam int REQ_W    = 40;
   localparam int RSP_W    = 48;

   typedef enum logic [1:0] {
      FN_INSERT,
      FN_REMOVE,
      FN_READ,
      FN_FIND
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_PUT,
      ST_DONE
   } state_type;

endpackage

// ----- hdl/sle_ram.sv -----
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sequential_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// Bounded ordered list of signed words kept in one RAM: insert, remove, read
// and find, each answered by one result item.
//
// Channel  Dir  Handshake                 Payload (lowest bit first)
// req      in   req_tvalid / req_tready   func, position, word
// rsp      out  rsp_tvalid / rsp_tready   ok, read_data, match_position,
//                                         fill_count
//
// An accepted item passes from idle through a RAM walk to one result load;
// a refused item goes straight to the result load. A walk issues RAM reads
// and then drains them; a find ends early on a match. Insert reads the
// entries from the position up to the fill and then stores the word, remove
// the entries above the position, read one entry, find up to the first
// match. A waiting result holds only the next result load. Reset clears the
// fill count, not the RAM.
// ----------------------------------------------------------------------------
module sequential_list_engine_core
   import sle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // func[1:0], position[6:2], word[38:7]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // ok[0], read_data[32:1],
                                         // match_position[36:33], fill_count[41:37]
);

   state_type         state_ff, state_in;
   func_type          op_ff, op_in;
   logic [FILL_W-1:0] pos_ff, pos_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] cnt_ff, cnt_in;
   logic [FILL_W-1:0] dst_ff, dst_in;
   logic              pend_ff, pend_in;
   logic              ok_ff, ok_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic [MPOS_W-1:0] mpos_ff, mpos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   func_type          req_func;
   logic [POS_W-1:0]  req_pos;
   logic [WORD_W-1:0] req_word;
   logic              req_accept;
   logic              legal;
   logic              issue;
   logic              match;
   logic              walk_done;
   logic              rsp_free;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [FILL_W-1:0] fill_next;

   assign req_func   = func_type'(req_tdata[1:0]);
   assign req_pos    = req_tdata[6:2];
   assign req_word   = req_tdata[38:7];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   sle_ram #(
      .WIDTH(WORD_W),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      unique case (req_func) inside
         FN_INSERT: legal = (CMP_W'(req_pos) <= CMP_W'(fill_ff)) &&
                            (fill_ff < FILL_W'(CAPACITY));
         FN_REMOVE, FN_READ: legal = (CMP_W'(req_pos) < CMP_W'(fill_ff));
         default: legal = 1'b1;
      endcase
   end

   // sequencer outputs: RAM access and walk control
   always_comb begin
      issue   = 1'b0;
      rd_addr = ADDR_W'(cnt_ff);
      if (state_ff == ST_WALK) begin
         unique case (op_ff)
            FN_INSERT: begin
               issue   = cnt_ff > pos_ff;
               rd_addr = ADDR_W'(cnt_ff - 1'b1);
            end
            FN_REMOVE: begin
               issue   = ({1'b0, cnt_ff} + 1'b1) < {1'b0, fill_ff};
               rd_addr = ADDR_W'(cnt_ff + 1'b1);
            end
            FN_READ: issue = (cnt_ff == pos_ff);
            default: issue = (cnt_ff < fill_ff);
         endcase
      end
      rd_en     = issue;
      match     = (state_ff == ST_WALK) && pend_ff && (op_ff == FN_FIND) &&
                  (rd_data == word_ff);
      walk_done = !issue && !pend_ff;
      wr_en     = 1'b0;
      wr_addr   = ADDR_W'(dst_ff);
      wr_data   = rd_data;
      if (state_ff == ST_WALK && pend_ff &&
          (op_ff == FN_INSERT || op_ff == FN_REMOVE)) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_PUT) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_W'(pos_ff);
         wr_data = word_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = legal ? ST_WALK : ST_DONE;
            end
         end
         ST_WALK: begin
            if (match) begin
               state_in = ST_DONE;
            end else if (walk_done) begin
               state_in = (op_ff == FN_INSERT) ? ST_PUT : ST_DONE;
            end
         end
         ST_PUT:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      fill_next = fill_ff;
      if (ok_ff && op_ff == FN_INSERT) begin
         fill_next = fill_ff + 1'b1;
      end else if (ok_ff && op_ff == FN_REMOVE) begin
         fill_next = fill_ff - 1'b1;
      end
   end

   always_comb begin
      op_in        = op_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      dst_in       = dst_ff;
      pend_in      = 1'b0;
      ok_in        = ok_ff;
      data_in      = data_ff;
      mpos_in      = mpos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         op_in   = req_func;
         pos_in  = FILL_W'(req_pos);
         word_in = req_word;
         ok_in   = legal && (req_func != FN_FIND);
         data_in = '0;
         mpos_in = '0;
         unique case (req_func)
            FN_INSERT: cnt_in = fill_ff;
            FN_FIND:   cnt_in = '0;
            default:   cnt_in = FILL_W'(req_pos);
         endcase
      end
      if (state_ff == ST_WALK) begin
         pend_in = issue && !match;
         if (issue) begin
            dst_in = cnt_ff;
            cnt_in = (op_ff == FN_INSERT) ? cnt_ff - 1'b1 : cnt_ff + 1'b1;
         end
         if (pend_ff && op_ff == FN_READ) begin
            data_in = rd_data;
         end
         if (match) begin
            ok_in   = 1'b1;
            mpos_in = MPOS_W'(dst_ff);
         end
      end
      if (state_ff == ST_DONE && rsp_free) begin
         fill_in      = fill_next;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, CNT_W'(fill_next), mpos_ff, data_ff, ok_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      word_ff     <= word_in;
      cnt_ff      <= cnt_in;
      dst_ff      <= dst_in;
      ok_ff       <= ok_in;
      data_ff     <= data_in;
      mpos_ff     <= mpos_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en && wr_addr == rd_addr))
      else $error("read and write of the same entry in one cycle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after an accepted item");

   a_pend_from_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == ST_WALK))
      else $error("pending read outside a walk");

   a_fill_at_done: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != $past(fill_ff)) |-> ($past(state_ff) == ST_DONE))
      else $error("fill count changed outside result load");
`endif

endmodule

// ----- verif/sequential_list_engine_core_tb.sv -----
// ----------------------------------------------------------------------------
// sequential_list_engine_core_tb
// Self-checking bench for the list engine. A shadow list, updated on every
// accepted request, predicts each response. A short directed run covers the
// empty list, refused inserts and out-of-range positions, the word extremes,
// duplicates and every operation. Random traffic follows in grow, shrink and
// mixed phases so the list fills and drains repeatedly. The sender sends in
// bursts with gaps, and the receiver stalls in rotating patterns, including
// one long hold that backs up the request side.
// ----------------------------------------------------------------------------
module sequential_list_engine_core_tb
   import sle_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 480;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      func_type    fn;
      logic [4:0]  pos;
      logic [31:0] word;
   } list_req_type;

   typedef struct {
      logic        ok;
      logic [31:0] read_data;
      logic [3:0]  match_pos;
      logic [4:0]  fill_count;
   } list_rsp_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // func[1:0], position[6:2], word[38:7]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // ok[0], read_data[32:1],
                                        // match_position[36:33], fill_count[41:37]

   list_req_type pending_reqs[$];
   list_rsp_type expected_rsps[$];

   // shadow list state
   logic [31:0] shadow_entries[CAPACITY];
   int          shadow_fill;

   // stimulus steering
   int          gen_fill;
   logic [31:0] word_pool[8];

   int          errors;
   int          op_count[4];
   int          ok_count;
   int          peak_fill;
   int          full_refusals;
   int          rsp_seen;

   // driver state
   list_req_type cur_req;
   int           burst_left;
   int           gap_left;

   // receiver state
   int           rx_cycle;
   int           hold_left;
   bit           hold_done;
   list_rsp_type got_rsp;
   list_rsp_type want_rsp;

   int          idle_cycles;

   sequential_list_engine_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   task automatic predict_list_op(input list_req_type r);
      list_rsp_type res;
      int           p;
      res = '{ok: 1'b0, read_data: '0, match_pos: '0, fill_count: '0};
      p = r.pos;
      op_count[r.fn]++;
      case (r.fn)
         FN_INSERT: begin
            if (p <= shadow_fill && shadow_fill < CAPACITY) begin
               for (int i = shadow_fill; i > p; i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[p] = r.word;
               shadow_fill++;
               res.ok = 1'b1;
            end else if (shadow_fill == CAPACITY) begin
               full_refusals++;
            end
         end
         FN_REMOVE: begin
            if (p < shadow_fill) begin
               for (int i = p; i + 1 < shadow_fill; i++)
                  shadow_entries[i] = shadow_entries[i+1];
               shadow_fill--;
               res.ok = 1'b1;
            end
         end
         FN_READ: begin
            if (p < shadow_fill) begin
               res.read_data = shadow_entries[p];
               res.ok = 1'b1;
            end
         end
         default: begin
            for (int i = 0; i < shadow_fill; i++) begin
               if (!res.ok && shadow_entries[i] == r.word) begin
                  res.ok = 1'b1;
                  res.match_pos = i[3:0];
               end
            end
         end
      endcase
      res.fill_count = shadow_fill[4:0];
      if (res.ok) ok_count++;
      if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      expected_rsps.push_back(res);
   endtask

   task automatic queue_request(input func_type fn, input int pos, input logic [31:0] w);
      list_req_type r;
      r.fn   = fn;
      r.pos  = pos[4:0];
      r.word = w;
      pending_reqs.push_back(r);
      case (fn)
         FN_INSERT: if (pos <= gen_fill && gen_fill < CAPACITY) gen_fill++;
         FN_REMOVE: if (pos < gen_fill) gen_fill--;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] pick_word(input int pool_pct);
      logic [31:0] w;
      int          roll;
      roll = $urandom_range(0, 99);
      if (roll < pool_pct) begin
         w = word_pool[$urandom_range(0, 7)];
      end else if (roll < pool_pct + 10) begin
         case ($urandom_range(0, 3))
            0:       w = 32'h8000_0000;
            1:       w = 32'h7FFF_FFFF;
            2:       w = 32'h0000_0000;
            default: w = 32'hFFFF_FFFF;
         endcase
      end else begin
         w = $urandom;
      end
      return w;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
         errors++;
      end
   endfunction

   // driver: bursts of items separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_list_op(cur_req);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_tdata  <= {1'b0, cur_req.word, cur_req.pos, cur_req.fn};
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: check responses, stall on a rotating pattern, one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_cycle   <= 0;
      end else begin
         rx_cycle++;
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.ok         = rsp_tdata[0];
            got_rsp.read_data  = rsp_tdata[32:1];
            got_rsp.match_pos  = rsp_tdata[36:33];
            got_rsp.fill_count = rsp_tdata[41:37];
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding: 0x%012h", rsp_tdata);
               errors++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               compare_field("ok", want_rsp.ok, got_rsp.ok);
               compare_field("read_data", want_rsp.read_data, got_rsp.read_data);
               compare_field("match_position", want_rsp.match_pos, got_rsp.match_pos);
               compare_field("fill_count", want_rsp.fill_count, got_rsp.fill_count);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_seen >= 150) begin
            hold_done = 1'b1;
            hold_left = 120;
            rsp_tready <= 1'b0;
         end else begin
            case ((rx_cycle / 50) % 4)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= $urandom_range(0, 1);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (rx_cycle % 4 != 0);
            endcase
         end
      end
   end

   // watchdog: abort when nothing moves on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      func_type    fn;
      int          phase;
      int          roll;
      int          pos;
      logic [31:0] w;

      for (int i = 0; i < 8; i++) word_pool[i] = $urandom;

      // empty list, refused inserts
      queue_request(FN_READ,   0,  32'h0);
      queue_request(FN_REMOVE, 0,  32'h0);
      queue_request(FN_FIND,   0,  32'h0);
      queue_request(FN_INSERT, 1,  32'h1111_1111);
      queue_request(FN_INSERT, 31, 32'h2222_2222);
      // build [0, -1, MIN, MAX]
      queue_request(FN_INSERT, 0,  32'h8000_0000);
      queue_request(FN_INSERT, 1,  32'h7FFF_FFFF);
      queue_request(FN_INSERT, 0,  32'h0000_0000);
      queue_request(FN_INSERT, 1,  32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++) queue_request(FN_READ, i, 32'h0);
      queue_request(FN_READ,   4,  32'h0);
      queue_request(FN_READ,   31, 32'hFFFF_FFFF);
      queue_request(FN_FIND,   31, 32'hFFFF_FFFF);
      queue_request(FN_FIND,   0,  32'h7FFF_FFFF);
      queue_request(FN_FIND,   0,  32'h1234_5678);
      // duplicate at front: find returns the first one
      queue_request(FN_INSERT, 0,  32'hFFFF_FFFF);
      queue_request(FN_FIND,   17, 32'hFFFF_FFFF);
      queue_request(FN_REMOVE, 4,  32'h0);
      queue_request(FN_REMOVE, 0,  32'h0);
      queue_request(FN_REMOVE, 4,  32'h0);
      queue_request(FN_REMOVE, 31, 32'h0);

      // random phases: grow, shrink, mixed
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         phase = (n / 40) % 3;
         roll  = $urandom_range(0, 99);
         case (phase)
            0:       fn = (roll < 60) ? FN_INSERT : (roll < 70) ? FN_REMOVE :
                          (roll < 85) ? FN_READ : FN_FIND;
            1:       fn = (roll < 10) ? FN_INSERT : (roll < 65) ? FN_REMOVE :
                          (roll < 80) ? FN_READ : FN_FIND;
            default: fn = (roll < 30) ? FN_INSERT : (roll < 55) ? FN_REMOVE :
                          (roll < 80) ? FN_READ : FN_FIND;
         endcase
         if (fn == FN_FIND || $urandom_range(0, 99) < 15) pos = $urandom_range(0, 31);
         else if (fn == FN_INSERT) pos = $urandom_range(0, gen_fill);
         else if (gen_fill > 0) pos = $urandom_range(0, gen_fill - 1);
         else pos = $urandom_range(0, 31);
         if (fn == FN_INSERT) begin
            w = pick_word(40);
            word_pool[$urandom_range(0, 7)] = w;
         end else if (fn == FN_FIND) begin
            w = pick_word(70);
         end else begin
            w = $urandom;
         end
         queue_request(fn, pos, w);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         $error("%0d responses never arrived", expected_rsps.size());
         errors++;
      end
      $display("Covered %0d inserts, %0d removes, %0d reads, %0d finds; %0d succeeded.",
               op_count[FN_INSERT], op_count[FN_REMOVE], op_count[FN_READ],
               op_count[FN_FIND], ok_count);
      $display("List peaked at %0d entries, %0d inserts refused on a full list, %0d errors.",
               peak_fill, full_refusals, errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
